// ----- hw/rtl/pprm_pkg.sv -----
// ----------------------------------------------------------------------------
// pprm_pkg
// Shared types and constants for the per-pixel running mean block.
// ----------------------------------------------------------------------------
package pprm_pkg;

    // fixed field widths at the ports
    localparam int IDX_BITS   = 16;
    localparam int FRAME_BITS = 16;
    localparam int SMP_BITS   = 16;
    localparam int MEAN_BITS  = 24;
    localparam int NUM_CH     = 4;

    // divisor is frame_number + 1
    localparam int DIVS_BITS  = FRAME_BITS + 1;

    // item kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // per-stage control word carried alongside the datapath
    typedef struct packed {
        logic                vld;
        logic                wr;
        logic                rd;
        logic                in_range;
        logic [IDX_BITS-1:0] idx;
    } stage_ctl_t;

endpackage

// ----- hw/rtl/pprm_ram.sv -----
// ----------------------------------------------------------------------------
// pprm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pprm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/pprm_update.sv -----
// ----------------------------------------------------------------------------
// pprm_update
// Pipelined mean update for one channel: next = mean + (sample - mean) / div,
// quotient truncated toward zero, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pprm_update
    import pprm_pkg::*;
#(
    parameter int W  = 24,
    parameter int FB = 8
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [W-FB-1:0]      sample,
    input  logic [W-1:0]         mean,
    input  logic                 first,
    input  logic [DIVS_BITS-1:0] divisor,
    output logic [W-1:0]         mean_new
);

    localparam int NQ = W;
    localparam int RW = DIVS_BITS + 1;

    logic [W:0]           scaled;
    logic [W:0]           mean_x;
    logic [W:0]           diff;
    logic [W-1:0]         mag;

    logic [NQ-1:0]        dvd_reg  [0:NQ];
    logic [RW-1:0]        rem_reg  [0:NQ];
    logic [NQ-1:0]        quo_reg  [0:NQ];
    logic [DIVS_BITS-1:0] dvs_reg  [0:NQ];
    logic [W-1:0]         mean_reg [0:NQ];
    logic                 neg_reg  [0:NQ];

    logic [W:0]           sq;
    logic [W:0]           sum;

    // difference and its magnitude; first frame sees a zero mean
    always_comb
    begin
        scaled = {1'b0, sample, {FB{1'b0}}};
        mean_x = first ? '0 : {1'b0, mean};
        diff   = scaled - mean_x;
        mag    = diff[W] ? W'(-diff) : diff[W-1:0];
    end

    // entry stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_reg[0]  <= mag;
            rem_reg[0]  <= '0;
            quo_reg[0]  <= '0;
            dvs_reg[0]  <= divisor;
            mean_reg[0] <= mean_x[W-1:0];
            neg_reg[0]  <= diff[W];
        end
    end

    // restoring division stages
    for (genvar k = 0; k < NQ; k++)
    begin : g_div
        logic [RW-1:0] rem_sh;
        logic          ge;

        always_comb
        begin
            rem_sh = {rem_reg[k][RW-2:0], dvd_reg[k][NQ-1]};
            ge     = (rem_sh >= {1'b0, dvs_reg[k]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? (rem_sh - {1'b0, dvs_reg[k]}) : rem_sh;
                dvd_reg[k+1]  <= dvd_reg[k] << 1;
                quo_reg[k+1]  <= {quo_reg[k][NQ-2:0], ge};
                dvs_reg[k+1]  <= dvs_reg[k];
                mean_reg[k+1] <= mean_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
            end
        end
    end

    // apply signed quotient
    always_comb
    begin
        sq       = neg_reg[NQ] ? -{1'b0, quo_reg[NQ]} : {1'b0, quo_reg[NQ]};
        sum      = {1'b0, mean_reg[NQ]} + sq;
        mean_new = sum[W-1:0];
    end

endmodule

// ----- hw/rtl/per_pixel_running_mean.sv -----
// ----------------------------------------------------------------------------
// per_pixel_running_mean
// Per-pixel running mean of four channels over a frame sequence.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): an add transfer (kind 0) folds the
// red, green, blue and alpha samples of frame frame_number into the mean of
// pixel pixel_index; frame 0 stores the samples. A read transfer (kind 1)
// returns the four stored 16.8 means on the output channel
// (out_valid/out_ready). Indices at or above PIXEL_COUNT: add is dropped,
// read returns zeros.
// Throughput: one transfer per cycle for differing pixels while no read
// result is held by a stalled receiver. An item whose pixel still has an
// add in stage 0 or the update pipeline waits until that write lands; the
// pipelined divider, one quotient bit per stage, sets that wait.
// Path: a read result is registered in stage 0 and then in the output
// register; an add goes through stage 0, entry and division stages.
// Reset clears pipeline and output valid state only; memory contents are
// undefined until frame 0 writes them. When the receiver stalls with a
// result held, a following read holds the whole pipeline.
// ----------------------------------------------------------------------------
module per_pixel_running_mean
    import pprm_pkg::*;
#(
    parameter int PIXEL_COUNT   = 65536,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [IDX_BITS-1:0]  pixel_index,
    input  logic [FRAME_BITS-1:0] frame_number,
    input  logic [SMP_BITS-1:0]  red_in,
    input  logic [SMP_BITS-1:0]  green_in,
    input  logic [SMP_BITS-1:0]  blue_in,
    input  logic [SMP_BITS-1:0]  alpha_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [MEAN_BITS-1:0] red_mean,
    output logic [MEAN_BITS-1:0] green_mean,
    output logic [MEAN_BITS-1:0] blue_mean,
    output logic [MEAN_BITS-1:0] alpha_mean
);

    localparam int W     = SAMPLE_BITS + FRACTION_BITS;
    localparam int DEPTH = (PIXEL_COUNT > 65536) ? 65536 : PIXEL_COUNT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int L     = W + 1;

    logic                 adv;
    logic                 hazard;
    logic                 accept;
    logic                 in_inside;

    stage_ctl_t           s0_ctl_reg;
    stage_ctl_t           ctl_reg [1:L];
    logic [FRAME_BITS-1:0] s0_frame_reg;
    logic [SAMPLE_BITS-1:0] s0_smp_reg [0:NUM_CH-1];

    logic [NUM_CH*W-1:0]  rd_data;
    logic [NUM_CH*W-1:0]  wr_data;
    logic                 wr_en;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [MEAN_BITS-1:0] mean_reg  [0:NUM_CH-1];
    logic [MEAN_BITS-1:0] mean_next [0:NUM_CH-1];
    logic [L-1:0]         hit;

    // stall only when a read result cannot enter the output register
    assign adv = !(s0_ctl_reg.vld && s0_ctl_reg.rd && out_valid_reg && !out_ready);

    // interlock against pending writes to the same pixel
    always_comb
    begin
        hit[0] = s0_ctl_reg.vld && s0_ctl_reg.wr && (s0_ctl_reg.idx == pixel_index);
        for (int k = 1; k < L; k++)
        begin
            hit[k] = ctl_reg[k].vld && ctl_reg[k].wr && (ctl_reg[k].idx == pixel_index);
        end
    end
    assign hazard = (|hit) ||
                    (ctl_reg[L].vld && ctl_reg[L].wr && (ctl_reg[L].idx == pixel_index));

    assign in_inside = (32'(pixel_index) < 32'(PIXEL_COUNT));
    assign in_ready  = adv && !hazard;
    assign accept    = in_valid && in_ready;

    // stage 0: memory read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s0_ctl_reg.vld      <= accept;
            s0_ctl_reg.wr       <= accept && (kind == KIND_ADD) && in_inside;
            s0_ctl_reg.rd       <= accept && (kind == KIND_READ);
            s0_ctl_reg.in_range <= in_inside;
            s0_ctl_reg.idx      <= pixel_index;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_frame_reg  <= frame_number;
            s0_smp_reg[0] <= red_in[SAMPLE_BITS-1:0];
            s0_smp_reg[1] <= green_in[SAMPLE_BITS-1:0];
            s0_smp_reg[2] <= blue_in[SAMPLE_BITS-1:0];
            s0_smp_reg[3] <= alpha_in[SAMPLE_BITS-1:0];
        end
    end

    // control shift line beside the update pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= L; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            ctl_reg[1] <= s0_ctl_reg;
            for (int k = 2; k <= L; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // mean memory, four channels side by side
    assign wr_en = adv && ctl_reg[L].vld && ctl_reg[L].wr;

    pprm_ram #(
        .WIDTH (NUM_CH * W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (ctl_reg[L].idx[AW-1:0]),
        .wdata (wr_data),
        .re    (adv),
        .raddr (pixel_index[AW-1:0]),
        .rdata (rd_data)
    );

    // one update pipeline per channel
    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_ch
        pprm_update #(
            .W  (W),
            .FB (FRACTION_BITS)
        ) u_update (
            .clk      (clk),
            .en       (adv),
            .sample   (s0_smp_reg[c]),
            .mean     (rd_data[c*W +: W]),
            .first    (s0_frame_reg == '0),
            .divisor  ({1'b0, s0_frame_reg} + DIVS_BITS'(1)),
            .mean_new (wr_data[c*W +: W])
        );

        logic [W+MEAN_BITS-1:0] wide;

        always_comb
        begin
            wide = {{MEAN_BITS{1'b0}}, rd_data[c*W +: W]};
            mean_next[c] = s0_ctl_reg.in_range ? wide[MEAN_BITS-1:0] : '0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (adv && s0_ctl_reg.vld && s0_ctl_reg.rd)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s0_ctl_reg.vld && s0_ctl_reg.rd)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                mean_reg[c] <= mean_next[c];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_mean   = mean_reg[0];
    assign green_mean = mean_reg[1];
    assign blue_mean  = mean_reg[2];
    assign alpha_mean = mean_reg[3];

endmodule

// ----- hw/rtl/pprm_checker.sv -----
// ----------------------------------------------------------------------------
// pprm_checker
// Port-level checks for the per-pixel running mean block.
// ----------------------------------------------------------------------------
module pprm_checker
    import pprm_pkg::*;
#(
    parameter int PIXEL_COUNT = 65536
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 kind,
    input logic [IDX_BITS-1:0]  pixel_index,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [MEAN_BITS-1:0] red_mean,
    input logic [MEAN_BITS-1:0] alpha_mean
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_mean) && $stable(alpha_mean))
        else $error("result changed while stalled");

    // an add is never followed at once by another transfer on the same pixel
    a_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_ADD) &&
        (32'(pixel_index) < 32'(PIXEL_COUNT))
        |=> !(in_valid && in_ready && (pixel_index == $past(pixel_index))))
        else $error("same pixel accepted while its update is pending");

    // a new result always stems from a read transfer through stage 0 and the output register
    a_read_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && (kind == KIND_READ), 2))
        else $error("result without a read transfer");

endmodule

bind per_pixel_running_mean pprm_checker #(
    .PIXEL_COUNT (PIXEL_COUNT)
) u_pprm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .pixel_index (pixel_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red_mean    (red_mean),
    .alpha_mean  (alpha_mean)
);
